// ----- rtl/core/ectc_pkg.sv -----
package ectc_pkg;

  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned DayHi      = SecPerDay / 128;
  localparam int unsigned QuadDays   = 4 * 365 + 1;
  localparam int unsigned DaysToBase = 24856;
  localparam int unsigned BaseShift  = 25202 - DaysToBase;
  localparam int unsigned BaseWday   = 2;
  localparam int unsigned Latency    = 11;

  localparam logic [3:0] MonJan = 4'd0;
  localparam logic [3:0] MonDec = 4'd11;

  typedef struct packed {
    logic [15:0] day_index;
    logic [16:0] sec_of_day;
  } split_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] year;
    logic [2:0] wday;
    logic [8:0] yday;
    logic       leap;
  } cal_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] s;
    case (mon)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && mon >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] n;
    case (mon)
      4'd1:                     n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/ectc_split.sv -----
module ectc_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [31:0]   secs,
  output logic                 out_valid,
  output ectc_pkg::split_t     out_data
);

  localparam logic [32:0] Bias = 33'(64'(ectc_pkg::DaysToBase) * 64'(ectc_pkg::SecPerDay));
  localparam logic [26:0] RecipDay = 27'((64'd1 << 36) / 64'(ectc_pkg::DayHi));

  logic [3:0]  v;
  logic [32:0] u;
  logic [25:0] x1;
  logic [6:0]  lo1, lo2;
  logic [16:0] qe1, qe2;
  logic [10:0] r2;
  logic [16:0] q3;
  logic [9:0]  r3;

  always_comb begin
    if (r2 >= 11'(ectc_pkg::DayHi)) begin
      q3 = qe2 + 17'd1;
      r3 = 10'(r2 - 11'(ectc_pkg::DayHi));
    end else begin
      q3 = qe2;
      r3 = r2[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], in_valid};
    end
    u   <= {secs[31], secs} + Bias;
    x1  <= u[32:7];
    lo1 <= u[6:0];
    qe1 <= 17'((53'(u[32:7]) * 53'(RecipDay)) >> 36);
    qe2 <= qe1;
    lo2 <= lo1;
    r2  <= 11'(x1 - 26'(qe1) * 26'(ectc_pkg::DayHi));
    out_data.day_index  <= 16'(q3 + 17'(ectc_pkg::BaseShift));
    out_data.sec_of_day <= {r3, lo2};
  end

  assign out_valid = v[3];

endmodule

// ----- rtl/core/ectc_calendar.sv -----
module ectc_calendar (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ectc_pkg::split_t  in_data,
  output logic              out_valid,
  output ectc_pkg::cal_t    out_data
);

  localparam logic [16:0] RecipQuad = 17'((64'd1 << 27) / 64'(ectc_pkg::QuadDays));
  localparam logic [13:0] RecipWeek = 14'((64'd1 << 16) / 64'd7);

  logic [5:0]  v;

  logic [4:0]  hour1;
  logic [11:0] remh1;
  logic [15:0] d1;
  logic [5:0]  q4e1;

  logic [4:0]  hour2;
  logic [5:0]  min2, sec2;
  logic [5:0]  q4e2;
  logic [11:0] r4raw2;

  logic [4:0]  hour3;
  logic [5:0]  min3, sec3;
  logic [5:0]  q43;
  logic [10:0] r43;

  ectc_pkg::cal_t c4;
  logic [10:0] wsum4;

  ectc_pkg::cal_t c5;
  logic [10:0] wsum5;
  logic [10:0] we5;

  logic [4:0]  hour_c;
  logic [11:0] remh_c;
  logic [5:0]  min_c;
  logic [5:0]  sec_c;
  logic [1:0]  yin_c;
  logic [3:0]  mon_c;
  logic [3:0]  w_c;

  ectc_pkg::cal_t c5_next;
  ectc_pkg::cal_t out_next;

  always_comb begin
    hour_c = '0;
    for (int h = 1; h < 24; h++) begin
      if (in_data.sec_of_day >= 17'(h * ectc_pkg::SecPerHour)) begin
        hour_c = 5'(h);
      end
    end
    remh_c = 12'(in_data.sec_of_day - 17'(hour_c) * 17'(ectc_pkg::SecPerHour));

    min_c = '0;
    for (int m = 1; m < 60; m++) begin
      if (remh1 >= 12'(m * ectc_pkg::SecPerMin)) begin
        min_c = 6'(m);
      end
    end
    sec_c = 6'(remh1 - 12'(min_c) * 12'(ectc_pkg::SecPerMin));

    if (r43 >= 11'd1095) begin
      yin_c = 2'd3;
    end else if (r43 >= 11'd730) begin
      yin_c = 2'd2;
    end else if (r43 >= 11'd365) begin
      yin_c = 2'd1;
    end else begin
      yin_c = 2'd0;
    end

    mon_c = ectc_pkg::MonJan;
    for (int m = 1; m < 12; m++) begin
      if (c4.yday >= ectc_pkg::month_start(c4.leap, 4'(m))) begin
        mon_c = 4'(m);
      end
    end

    w_c = 4'(wsum5 - 11'(we5[7:0]) * 11'd7);
    if (w_c >= 4'd7) begin
      w_c = w_c - 4'd7;
    end

    c5_next      = c4;
    c5_next.mon  = mon_c;
    c5_next.mday = 5'(c4.yday - ectc_pkg::month_start(c4.leap, mon_c) + 9'd1);

    out_next      = c5;
    out_next.wday = w_c[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end

    hour1 <= hour_c;
    remh1 <= remh_c;
    d1    <= in_data.day_index;
    q4e1  <= 6'((33'(in_data.day_index) * 33'(RecipQuad)) >> 27);

    hour2  <= hour1;
    min2   <= min_c;
    sec2   <= sec_c;
    q4e2   <= q4e1;
    r4raw2 <= 12'(d1 - 16'(q4e1) * 16'(ectc_pkg::QuadDays));

    hour3 <= hour2;
    min3  <= min2;
    sec3  <= sec2;
    if (r4raw2 >= 12'(ectc_pkg::QuadDays)) begin
      q43 <= q4e2 + 6'd1;
      r43 <= 11'(r4raw2 - 12'(ectc_pkg::QuadDays));
    end else begin
      q43 <= q4e2;
      r43 <= r4raw2[10:0];
    end

    c4.second <= sec3;
    c4.minute <= min3;
    c4.hour   <= hour3;
    c4.mday   <= '0;
    c4.mon    <= ectc_pkg::MonJan;
    c4.wday   <= '0;
    c4.yday   <= 9'(r43 - 11'(yin_c) * 11'd365);
    c4.leap   <= (yin_c == 2'd3);
    c4.year   <= 8'(8'd1 + {q43, 2'b00} + 8'(yin_c));
    wsum4     <= 11'(11'(ectc_pkg::BaseWday) + 11'(q43) * 11'd5 + r43);

    c5    <= c5_next;
    wsum5 <= wsum4;
    we5   <= 11'((25'(wsum4) * 25'(RecipWeek)) >> 16);

    out_data <= out_next;
  end

  assign out_valid = v[5];

endmodule

// ----- rtl/core/ectc_zone.sv -----
module ectc_zone (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ectc_pkg::cal_t     in_data,
  input  logic signed [4:0]  offset,
  output logic               out_valid,
  output ectc_pkg::cal_t     out_data
);

  logic signed [6:0] h;
  logic [7:0]        prev_year;
  ectc_pkg::cal_t    c;

  always_comb begin
    h = $signed({2'b00, in_data.hour}) - 7'(offset);
    prev_year = in_data.year - 8'd1;
    c = in_data;
    if (h >= 7'sd24) begin
      c.hour = 5'(h - 7'sd24);
      c.yday = in_data.yday + 9'd1;
      c.wday = (in_data.wday == 3'd6) ? 3'd0 : in_data.wday + 3'd1;
      if (in_data.mday >= ectc_pkg::month_len(in_data.leap, in_data.mon)) begin
        c.mday = 5'd1;
        if (in_data.mon == ectc_pkg::MonDec) begin
          c.mon  = ectc_pkg::MonJan;
          c.year = in_data.year + 8'd1;
          c.yday = '0;
        end else begin
          c.mon = in_data.mon + 4'd1;
        end
      end else begin
        c.mday = in_data.mday + 5'd1;
      end
    end else if (h < 7'sd0) begin
      c.hour = 5'(h + 7'sd24);
      c.yday = in_data.yday - 9'd1;
      c.wday = (in_data.wday == 3'd0) ? 3'd6 : in_data.wday - 3'd1;
      if (in_data.mday == 5'd1) begin
        if (in_data.mon == ectc_pkg::MonJan) begin
          c.mon  = ectc_pkg::MonDec;
          c.year = prev_year;
          c.yday = (prev_year[1:0] == 2'b00) ? 9'd365 : 9'd364;
        end else begin
          c.mon = in_data.mon - 4'd1;
        end
        c.mday = ectc_pkg::month_len(in_data.leap, c.mon);
      end else begin
        c.mday = in_data.mday - 5'd1;
      end
    end else begin
      c.hour = h[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= c;
  end

endmodule

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// Converts a signed 32-bit count of seconds since 1970-01-01 UTC into calendar
// fields, shifted by the whole-hour tz_offset_hours register (reset -8, i.e.
// UTC+8). A beat is taken whenever start is high; busy is always low, so one
// beat per cycle is sustained. Each result appears on done after its start has
// passed the pipeline: four stages split days and seconds, six walk time of day,
// year, month and weekday, one applies the zone. The receiver cannot stall, so
// results must be consumed in the cycle shown.
module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] epoch_seconds,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               done,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month,
  output logic [7:0]         years_since_1900,
  output logic [2:0]         weekday,
  output logic [8:0]         day_of_year
);

  logic signed [4:0] tz_offset_hours;
  logic              split_valid, cal_valid;
  ectc_pkg::split_t  split_data;
  ectc_pkg::cal_t    cal_data, res;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{27{tz_offset_hours[4]}}, tz_offset_hours} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_offset_hours <= -5'sd8;
    end else if (psel && penable && pwrite && pready) begin
      tz_offset_hours <= pwdata[4:0];
    end
  end

  ectc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .secs      (epoch_seconds),
    .out_valid (split_valid),
    .out_data  (split_data)
  );

  ectc_calendar u_cal (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_data   (split_data),
    .out_valid (cal_valid),
    .out_data  (cal_data)
  );

  ectc_zone u_zone (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cal_valid),
    .in_data   (cal_data),
    .offset    (tz_offset_hours),
    .out_valid (done),
    .out_data  (res)
  );

  assign second           = res.second;
  assign minute           = res.minute;
  assign hour             = res.hour;
  assign day_of_month     = res.mday;
  assign month            = res.mon;
  assign years_since_1900 = res.year;
  assign weekday          = res.wday;
  assign day_of_year      = res.yday;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, ectc_pkg::Latency))
    else $error("result beat without matching start");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour < 5'd24 && month < 4'd12 && weekday < 3'd7 && day_of_month != 5'd0))
    else $error("calendar field out of range");

  a_newyear: assert property (@(posedge clk) disable iff (rst)
    done |-> ((day_of_year == 9'd0) == (month == ectc_pkg::MonJan && day_of_month == 5'd1)))
    else $error("day of year disagrees with month and day");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int second;
    int minute;
    int hour;
    int mday;
    int mon;
    int year;
    int wday;
    int yday;
  } civil_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] epoch_seconds = '0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               done;
  logic [5:0]         second;
  logic [5:0]         minute;
  logic [4:0]         hour;
  logic [4:0]         day_of_month;
  logic [3:0]         month;
  logic [7:0]         years_since_1900;
  logic [2:0]         weekday;
  logic [8:0]         day_of_year;

  localparam logic [1:0] AddrTzOffset = 2'd0;

  logic signed [31:0] pending_secs[$];
  civil_t             expected_cal[$];
  int                 zone_hours = -8;
  int                 gap_left = 0;
  bit                 quiet = 1'b0;
  int                 errors = 0;
  int                 beats_in = 0;
  int                 beats_out = 0;
  int                 zones_run = 1;

  epoch_seconds_to_calendar uut (.*);

  always #1 clk = ~clk;

  function automatic int is_leap(input int y);
    return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
  endfunction

  function automatic int days_in_month(input int lp, input int m);
    case (m)
      1:            return lp ? 29 : 28;
      3, 5, 8, 10:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic longint days_to_jan1(input int y);
    longint d;
    d = 0;
    for (int k = 1970; k < y; k++) d += 365 + is_leap(k);
    for (int k = y; k < 1970; k++) d -= 365 + is_leap(k);
    return d;
  endfunction

  function automatic civil_t to_calendar(input logic signed [31:0] s, input int tz);
    civil_t c;
    longint secs;
    longint days;
    longint rem;
    int lp;
    secs = s;
    days = secs / 86400;
    rem = secs % 86400;
    if (rem < 0) begin
      rem += 86400;
      days -= 1;
    end
    c.hour = int'(rem / 3600);
    rem = rem % 3600;
    c.minute = int'(rem / 60);
    c.second = int'(rem % 60);
    c.wday = int'((4 + days) % 7);
    if (c.wday < 0) c.wday += 7;
    c.year = 1970;
    if (days >= 0) begin
      forever begin
        lp = is_leap(c.year);
        if (days < 365 + lp) break;
        days -= 365 + lp;
        c.year++;
      end
    end else begin
      do begin
        c.year--;
        lp = is_leap(c.year);
        days += 365 + lp;
      end while (days < 0);
    end
    c.yday = int'(days);
    c.mon = 0;
    while (c.mon < 11 && days >= days_in_month(lp, c.mon)) begin
      days -= days_in_month(lp, c.mon);
      c.mon++;
    end
    c.mday = int'(days) + 1;
    c.hour -= tz;
    if (c.hour >= 24) begin
      c.hour -= 24;
      c.yday++;
      c.wday = (c.wday == 6) ? 0 : c.wday + 1;
      c.mday++;
      if (c.mday > days_in_month(lp, c.mon)) begin
        c.mday = 1;
        c.mon++;
        if (c.mon == 12) begin
          c.mon = 0;
          c.year++;
          c.yday = 0;
        end
      end
    end else if (c.hour < 0) begin
      c.hour += 24;
      c.yday--;
      c.wday = (c.wday == 0) ? 6 : c.wday - 1;
      c.mday--;
      if (c.mday == 0) begin
        c.mon--;
        if (c.mon < 0) begin
          c.mon = 11;
          c.year--;
          c.yday = 364 + is_leap(c.year);
        end
        c.mday = days_in_month(lp, c.mon);
      end
    end
    c.year -= 1900;
    return c;
  endfunction

  // hold start while items are pending, with random gaps unless quiet is set
  always @(posedge clk) begin
    civil_t c;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        c = to_calendar(epoch_seconds, zone_hours);
        expected_cal.push_back(c);
        void'(pending_secs.pop_front());
        beats_in++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_secs.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          epoch_seconds <= pending_secs[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    civil_t c;
    if (!rst && done) begin
      if (expected_cal.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        c = expected_cal.pop_front();
        beats_out++;
        if (second != 6'(c.second)) begin
          $error("second exp %0d got %0d", c.second, second); errors++;
        end
        if (minute != 6'(c.minute)) begin
          $error("minute exp %0d got %0d", c.minute, minute); errors++;
        end
        if (hour != 5'(c.hour)) begin
          $error("hour exp %0d got %0d", c.hour, hour); errors++;
        end
        if (day_of_month != 5'(c.mday)) begin
          $error("day_of_month exp %0d got %0d", c.mday, day_of_month); errors++;
        end
        if (month != 4'(c.mon)) begin
          $error("month exp %0d got %0d", c.mon, month); errors++;
        end
        if (years_since_1900 != 8'(c.year)) begin
          $error("years_since_1900 exp %0d got %0d", c.year, years_since_1900); errors++;
        end
        if (weekday != 3'(c.wday)) begin
          $error("weekday exp %0d got %0d", c.wday, weekday); errors++;
        end
        if (day_of_year != 9'(c.yday)) begin
          $error("day_of_year exp %0d got %0d", c.yday, day_of_year); errors++;
        end
      end
    end
  end

  task automatic write_zone(input int tz);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrTzOffset;
    pwdata <= 32'(tz);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    zone_hours = tz;
    zones_run++;
  endtask

  task automatic drain;
    while (pending_secs.size() > 0 || expected_cal.size() > 0) @(posedge clk);
    repeat (ectc_pkg::Latency + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] clip(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  task automatic queue_random(input int n);
    longint d;
    int y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: pending_secs.push_back($urandom);
        1: begin
          d = longint'($urandom_range(0, 49710)) - 24855;
          pending_secs.push_back(clip(d * 86400 + longint'($urandom_range(0, 86399))));
        end
        2: begin
          d = longint'($urandom_range(0, 49710)) - 24855;
          pending_secs.push_back(clip(d * 86400 + (int'($urandom_range(0, 32)) - 16) * 3600
                                      + longint'($urandom_range(0, 3599))));
        end
        default: begin
          y = $urandom_range(1902, 2038);
          d = days_to_jan1(y);
          pending_secs.push_back(clip(d * 86400 + (int'($urandom_range(0, 40)) - 20) * 3600
                                      + longint'($urandom_range(0, 3599))));
        end
      endcase
    end
  endtask

  initial begin
    int zones[] = '{-16, -12, 0, 14, 15, 7, -3};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // extremes, day and year boundaries, leap day
    pending_secs = '{0, -1, 32'sh7fffffff, 32'sh80000000, 86399, 86400, -86400, -86401,
                     946684799, 946684800, 951782400, 951868799, 915148799, 57600,
                     57599, -28800, -28801, 68169600, 1709164800, 4107542399,
                     32'sh7fff0000, 32'sh80010000, 1234567890, -1234567890};
    queue_random(220);
    drain();
    foreach (zones[k]) begin
      write_zone(zones[k]);
      if (k == zones.size() - 1) quiet = 1'b1;
      queue_random(245);
      drain();
    end
    $display("Checked %0d conversions over %0d zone offsets, %0d results compared",
             beats_in, zones_run, beats_out);
    if (errors == 0) begin
      $display("PASS epoch_seconds_to_calendar");
    end else begin
      $display("FAIL epoch_seconds_to_calendar");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL epoch_seconds_to_calendar");
    $finish;
  end

endmodule
